>>> rtl/sms_pkg.sv
// Shared constants, types and state encoding for the stable merge sorter.
package sms_pkg;

	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// pointers reach lo + 2*width, which stays below 3*DEPTH
	localparam int PTR_W  = CNT_W + 1;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS_CHK,
		ST_RUN_INIT,
		ST_MERGE_RD,
		ST_MERGE_WR,
		ST_RUN_CHK,
		ST_OUT_RD,
		ST_OUT_LOAD,
		ST_EMIT
	} sms_state_t;

	typedef struct packed {
		logic load_en;
		logic sort_init;
		logic pass_start;
		logic run_init;
		logic merge_wr;
		logic pass_next;
		logic out_init;
		logic out_rd;
		logic out_load;
		logic batch_done;
	} sms_cmd_t;

	typedef struct packed {
		logic width_ge_n;
		logic lo_ge_n;
		logic run_last;
		logic out_last;
	} sms_status_t;

endpackage

>>> rtl/sms_datapath.sv
// Datapath: element banks, merge pointers, comparator and output register.
module sms_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sms_pkg::sms_cmd_t          cmd,
	output sms_pkg::sms_status_t       status,
	input  logic signed [31:0]         value,
	output logic signed [31:0]         sorted_value,
	output logic                       last_out,
	output logic                       dropped
);
	import sms_pkg::*;

	// two banks, ping-ponged between merge passes
	logic [WORD_W-1:0] bank_a [DEPTH];
	logic [WORD_W-1:0] bank_b [DEPTH];

	logic [CNT_W-1:0]  fill_q;
	logic              ovf_q;
	logic              src_q;      // 0: bank A holds the current runs
	logic [PTR_W-1:0]  width_q;
	logic [PTR_W-1:0]  lo_q;
	logic [PTR_W-1:0]  a_q;
	logic [PTR_W-1:0]  b_q;
	logic [PTR_W-1:0]  mid_q;
	logic [PTR_W-1:0]  hi_q;
	logic [PTR_W-1:0]  k_q;

	logic [WORD_W-1:0] rda0_q, rda1_q, rdb0_q, rdb1_q;
	logic [WORD_W-1:0] sorted_value_q;
	logic              last_out_q;
	logic              dropped_q;

	logic [PTR_W-1:0]  n_ext;
	logic [PTR_W-1:0]  mid_raw, hi_raw;
	logic [ADDR_W-1:0] rd_addr0, rd_addr1, wr_addr;
	logic [WORD_W-1:0] head_a, head_b, merge_data, wr_data;
	logic              take_b;
	logic              store_ok;
	logic              wr_a, wr_b;
	logic [PTR_W-1:0]  k_next;

	assign n_ext    = PTR_W'(fill_q);
	assign store_ok = cmd.load_en && (fill_q < DEPTH_C);
	assign k_next   = k_q + PTR_W'(1);

	// raw run bounds, clipped to the batch size when a run starts
	assign mid_raw = lo_q + width_q;
	assign hi_raw  = lo_q + (width_q << 1);

	// pick the heads of both runs from the source bank
	assign head_a = src_q ? rdb0_q : rda0_q;
	assign head_b = src_q ? rdb1_q : rda1_q;

	// left run wins ties; exhausted runs yield to the other
	always_comb begin
		if (a_q >= mid_q) begin
			take_b = 1'b1;
		end else if (b_q >= hi_q) begin
			take_b = 1'b0;
		end else begin
			take_b = $signed(head_a) > $signed(head_b);
		end
	end
	assign merge_data = take_b ? head_b : head_a;

	// memory addressing
	assign rd_addr0 = cmd.out_rd ? k_q[ADDR_W-1:0] : a_q[ADDR_W-1:0];
	assign rd_addr1 = b_q[ADDR_W-1:0];
	assign wr_addr  = cmd.load_en ? fill_q[ADDR_W-1:0] : k_q[ADDR_W-1:0];
	assign wr_data  = cmd.load_en ? value : merge_data;
	assign wr_a     = store_ok || (cmd.merge_wr && src_q);
	assign wr_b     = cmd.merge_wr && !src_q;

	// write and read the banks
	always_ff @(posedge clk) begin
		if (wr_a) begin
			bank_a[wr_addr] <= wr_data;
		end
		if (wr_b) begin
			bank_b[wr_addr] <= wr_data;
		end
		rda0_q <= bank_a[rd_addr0];
		rda1_q <= bank_a[rd_addr1];
		rdb0_q <= bank_b[rd_addr0];
		rdb1_q <= bank_b[rd_addr1];
	end

	// batch fill and overflow tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.batch_done) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.load_en) begin
			if (store_ok) begin
				fill_q <= fill_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// pass, run and merge pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= 1'b0;
			width_q <= '0;
			lo_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.sort_init) begin
				src_q   <= 1'b0;
				width_q <= PTR_W'(1);
			end
			if (cmd.pass_start) begin
				lo_q <= '0;
			end
			if (cmd.run_init) begin
				a_q   <= lo_q;
				k_q   <= lo_q;
				mid_q <= (mid_raw > n_ext) ? n_ext : mid_raw;
				b_q   <= (mid_raw > n_ext) ? n_ext : mid_raw;
				hi_q  <= (hi_raw > n_ext) ? n_ext : hi_raw;
			end
			if (cmd.merge_wr) begin
				k_q <= k_next;
				if (take_b) begin
					b_q <= b_q + PTR_W'(1);
				end else begin
					a_q <= a_q + PTR_W'(1);
				end
				if (k_next == hi_q) begin
					lo_q <= hi_raw;
				end
			end
			if (cmd.pass_next) begin
				width_q <= width_q << 1;
				src_q   <= !src_q;
			end
			if (cmd.out_init) begin
				k_q <= '0;
			end
			if (cmd.out_load) begin
				k_q <= k_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sorted_value_q <= src_q ? rdb0_q : rda0_q;
			last_out_q     <= (k_next == n_ext);
			dropped_q      <= ovf_q;
		end
	end

	assign sorted_value = sorted_value_q;
	assign last_out     = last_out_q;
	assign dropped      = dropped_q;

	assign status.width_ge_n = (width_q >= n_ext);
	assign status.lo_ge_n    = (lo_q >= n_ext);
	assign status.run_last   = (k_next == hi_q);
	assign status.out_last   = last_out_q;

	// a merge write stays inside its run and draws from a live run
	a_merge_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_wr |-> (k_q < hi_q) && ((a_q < mid_q) || (b_q < hi_q)))
		else $error("merge write outside its run");

	// run pointers never pass their bounds
	a_ptr_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_wr |-> (a_q <= mid_q) && (b_q <= hi_q) && (mid_q <= hi_q))
		else $error("run pointer beyond its bound");

	// fill count never exceeds the buffer depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond depth");

	// a batch close clears fill and overflow on the next cycle
	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.batch_done |=> (fill_q == '0) && !ovf_q)
		else $error("batch state not cleared");

endmodule

>>> rtl/sms_controller.sv
// Controller: sequences load, merge passes and result emission.
module sms_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  last,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  sms_pkg::sms_status_t  status,
	output sms_pkg::sms_cmd_t     cmd
);
	import sms_pkg::*;

	sms_state_t state_q, state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && last) begin
					state_next = ST_PASS_CHK;
				end
			end
			ST_PASS_CHK: begin
				state_next = status.width_ge_n ? ST_OUT_RD : ST_RUN_INIT;
			end
			ST_RUN_INIT: begin
				state_next = ST_MERGE_RD;
			end
			ST_MERGE_RD: begin
				state_next = ST_MERGE_WR;
			end
			ST_MERGE_WR: begin
				state_next = status.run_last ? ST_RUN_CHK : ST_MERGE_RD;
			end
			ST_RUN_CHK: begin
				state_next = status.lo_ge_n ? ST_PASS_CHK : ST_RUN_INIT;
			end
			ST_OUT_RD: begin
				state_next = ST_OUT_LOAD;
			end
			ST_OUT_LOAD: begin
				state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready) begin
					state_next = status.out_last ? ST_LOAD : ST_OUT_RD;
				end
			end
			default: begin
				state_next = ST_LOAD;
			end
		endcase
	end

	// commands and handshake outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready      = 1'b1;
				cmd.load_en   = in_valid;
				cmd.sort_init = in_valid && last;
			end
			ST_PASS_CHK: begin
				cmd.out_init   = status.width_ge_n;
				cmd.pass_start = !status.width_ge_n;
			end
			ST_RUN_INIT: begin
				cmd.run_init = 1'b1;
			end
			ST_MERGE_RD: begin
			end
			ST_MERGE_WR: begin
				cmd.merge_wr = 1'b1;
			end
			ST_RUN_CHK: begin
				cmd.pass_next = status.lo_ge_n;
			end
			ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
			end
			ST_OUT_LOAD: begin
				cmd.out_load = 1'b1;
			end
			ST_EMIT: begin
				out_valid      = 1'b1;
				cmd.batch_done = out_ready && status.out_last;
			end
			default: begin
			end
		endcase
	end

	// input and output sides are never open together
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open at once");

	// a closing transfer starts the sort
	a_close_sorts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last) |=> (state_q == ST_PASS_CHK))
		else $error("batch close did not start sort");

	// the final result transfer returns to loading
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.batch_done |=> in_ready)
		else $error("no return to loading after batch");

endmodule

>>> rtl/stable_merge_sorter_unit.sv
// Loading: one transfer per cycle; the closing transfer starts the sort.
// Sort: ceil(log2 n) merge passes; each pass checks the width, then per run sets up the pointers,
// runs the single read/compare/write loop over the two element banks and checks the run end.
// Emission: each result goes through bank read, output load and transfer, plus any stall.
// One batch at a time: a new batch is not accepted until the last result is taken.
// Reset: arst_n clears control state and fill count; bank contents are undefined.
module stable_merge_sorter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sorted_value,
	output logic               last_out,
	output logic               dropped
);
	import sms_pkg::*;

	sms_cmd_t    cmd;
	sms_status_t status;

	// sequencing
	sms_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// storage and merge logic
	sms_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (value),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.dropped      (dropped)
	);

endmodule
